>>> design/tkbd_pkg.sv
// Package for the touch key baseline detector.
// Holds widths, register codes, reset values and the shared struct types.
// No dependencies; compile first.
`default_nettype none

package tkbd_pkg;

	localparam int COUNT_BITS = 16;
	localparam int AVG_LENGTH = 32;
	localparam int AVG_SHIFT  = $clog2(AVG_LENGTH);
	localparam int SUM_W      = COUNT_BITS + AVG_SHIFT;
	localparam int RUN_W      = 8;
	localparam int TALLY_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [RUN_W-1:0]      run_t;
	typedef logic [TALLY_W-1:0]    tally_t;
	typedef logic [SUM_W-1:0]      sum_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESS_THRESHOLD   = 3'd0,
		CFG_RELEASE_MARGIN    = 3'd1,
		CFG_PRESS_CONFIRM     = 3'd2,
		CFG_RELEASE_CONFIRM   = 3'd3,
		CFG_PRESSED_TRACK_PER = 3'd4
	} cfg_reg_t;

	localparam logic [15:0] RST_PRESS_THRESHOLD   = 16'd30;
	localparam logic [15:0] RST_RELEASE_MARGIN    = 16'd40;
	localparam logic [7:0]  RST_PRESS_CONFIRM     = 8'd8;
	localparam logic [7:0]  RST_RELEASE_CONFIRM   = 8'd4;
	localparam logic [7:0]  RST_PRESSED_TRACK_PER = 8'd3;

	typedef struct packed {
		logic [15:0] press_threshold;
		logic [15:0] release_margin;
		logic [7:0]  press_confirm_count;
		logic [7:0]  release_confirm_count;
		logic [7:0]  pressed_track_period;
	} cfg_t;

	typedef struct packed {
		logic   key_pressed;
		count_t filtered_count;
		count_t baseline_level;
	} result_t;

endpackage

`default_nettype wire

>>> design/tkbd_if.sv
// Valid/ready channel interfaces for the touch key baseline detector.
// Depends on tkbd_pkg.
`default_nettype none

interface tkbd_sample_if;
	import tkbd_pkg::*;
	logic   valid;
	logic   ready;
	count_t raw_count;

	modport source (output valid, output raw_count, input ready);
	modport sink   (input valid, input raw_count, output ready);
endinterface

interface tkbd_result_if;
	import tkbd_pkg::*;
	logic   valid;
	logic   ready;
	logic   key_pressed;
	count_t filtered_count;
	count_t baseline_level;

	modport source (output valid, output key_pressed, output filtered_count,
		output baseline_level, input ready);
	modport sink   (input valid, input key_pressed, input filtered_count,
		input baseline_level, output ready);
endinterface

`default_nettype wire

>>> design/tkbd_cfg.sv
// Configuration register file: five write-only tuning registers.
// Depends on tkbd_pkg.
`default_nettype none

module tkbd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [tkbd_pkg::CFG_IDX_W-1:0]    index,
	input  logic [tkbd_pkg::CFG_DATA_W-1:0]   data,
	output tkbd_pkg::cfg_t                    cfg
);
	import tkbd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_threshold       <= RST_PRESS_THRESHOLD;
			cfg_q.release_margin        <= RST_RELEASE_MARGIN;
			cfg_q.press_confirm_count   <= RST_PRESS_CONFIRM;
			cfg_q.release_confirm_count <= RST_RELEASE_CONFIRM;
			cfg_q.pressed_track_period  <= RST_PRESSED_TRACK_PER;
		end else if (we) begin
			unique case (cfg_reg_t'(index))
				CFG_PRESS_THRESHOLD:   cfg_q.press_threshold       <= data[15:0];
				CFG_RELEASE_MARGIN:    cfg_q.release_margin        <= data[15:0];
				CFG_PRESS_CONFIRM:     cfg_q.press_confirm_count   <= data[7:0];
				CFG_RELEASE_CONFIRM:   cfg_q.release_confirm_count <= data[7:0];
				CFG_PRESSED_TRACK_PER: cfg_q.pressed_track_period  <= data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/tkbd_core.sv
// Per-sample update: filter, baseline tracking and press/release detection.
// Holds the tracker state; updates it on each advancing beat. Depends on tkbd_pkg.
`default_nettype none

module tkbd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  tkbd_pkg::count_t     raw_count,
	input  tkbd_pkg::cfg_t       cfg,
	output tkbd_pkg::result_t    result
);
	import tkbd_pkg::*;

	localparam logic [TALLY_W:0] AVG_LEN_T = (TALLY_W+1)'(AVG_LENGTH);

	count_t smoothed_q, baseline_q, rel_ref_q;
	sum_t   sum_q;
	tally_t tally_q;
	run_t   touch_run_q, release_run_q;
	logic   held_q, fresh_q;

	count_t smoothed_n, baseline_n, rel_ref_n;
	sum_t   sum_n;
	tally_t tally_n;
	run_t   touch_run_n, release_run_n;
	logic   held_n, fresh_n;

	logic [COUNT_BITS+1:0] acc;
	count_t                f;
	logic [COUNT_BITS:0]   pv_sum;
	count_t                pv;
	run_t                  touch_inc, release_inc;
	logic [TALLY_W:0]      tally_inc;
	sum_t                  sum_add;
	count_t                rise;

	always_comb begin
		// first-order filter, (3*old + new) / 4 floored
		acc = {1'b0, smoothed_q, 1'b0} + {2'b00, smoothed_q} + {2'b00, raw_count};
		f   = acc[COUNT_BITS+1:2];

		pv_sum = {1'b0, f} + {1'b0, cfg.press_threshold};
		pv     = pv_sum[COUNT_BITS] ? '1 : pv_sum[COUNT_BITS-1:0];

		touch_inc   = (touch_run_q == '1) ? touch_run_q : touch_run_q + 1'b1;
		release_inc = (release_run_q == '1) ? release_run_q : release_run_q + 1'b1;
		tally_inc   = {1'b0, tally_q} + 1'b1;
		sum_add     = sum_q + {{AVG_SHIFT{1'b0}}, f};

		smoothed_n    = f;
		baseline_n    = baseline_q;
		rel_ref_n     = rel_ref_q;
		sum_n         = sum_q;
		tally_n       = tally_q;
		touch_run_n   = touch_run_q;
		release_run_n = release_run_q;
		held_n        = held_q;
		fresh_n       = fresh_q;
		rise          = '0;

		if (!held_q) begin
			if (pv < baseline_q) begin
				touch_run_n = touch_inc;
				if (touch_inc >= cfg.press_confirm_count) begin
					held_n    = 1'b1;
					rel_ref_n = (baseline_q > cfg.press_threshold) ?
						baseline_q - cfg.press_threshold : '0;
				end
			end else begin
				touch_run_n = '0;
				tally_n     = tally_inc[TALLY_W-1:0];
				sum_n       = sum_add;
				if (tally_inc >= AVG_LEN_T) begin
					tally_n    = '0;
					baseline_n = sum_add[SUM_W-1:AVG_SHIFT];
					sum_n      = '0;
					if (fresh_q) begin
						fresh_n    = 1'b0;
						baseline_n = f;
					end
				end
				// fast upward tracking right after a release
				if (fresh_n && (f > baseline_n))
					baseline_n = f;
			end
		end else begin
			touch_run_n = '0;
			tally_n     = tally_inc[TALLY_W-1:0];
			if (tally_inc >= {1'b0, cfg.pressed_track_period}) begin
				tally_n    = '0;
				baseline_n = (f <= baseline_q) ? f : baseline_q + 1'b1;
			end
			rise = (f > baseline_n) ? f - baseline_n : '0;
			if ((f > rel_ref_q) || (rise > cfg.release_margin)) begin
				release_run_n = release_inc;
				if (release_inc >= cfg.release_confirm_count) begin
					release_run_n = '0;
					held_n        = 1'b0;
					baseline_n    = f;
					tally_n       = '0;
					sum_n         = '0;
					fresh_n       = 1'b1;
				end
			end else begin
				release_run_n = '0;
			end
		end

		result.key_pressed    = held_n;
		result.filtered_count = f;
		result.baseline_level = baseline_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q    <= '0;
			baseline_q    <= '0;
			rel_ref_q     <= '0;
			sum_q         <= '0;
			tally_q       <= '0;
			touch_run_q   <= '0;
			release_run_q <= '0;
			held_q        <= 1'b0;
			fresh_q       <= 1'b0;
		end else if (advance) begin
			smoothed_q    <= smoothed_n;
			baseline_q    <= baseline_n;
			rel_ref_q     <= rel_ref_n;
			sum_q         <= sum_n;
			tally_q       <= tally_n;
			touch_run_q   <= touch_run_n;
			release_run_q <= release_run_n;
			held_q        <= held_n;
			fresh_q       <= fresh_n;
		end
	end

endmodule

`default_nettype wire

>>> design/touch_key_baseline_detector_unit.sv
// Touch key baseline detector, top level.
// Depends on tkbd_pkg, tkbd_if, tkbd_cfg and tkbd_core.
//
// Takes one raw capacitive conversion count per beat and returns one result
// beat per sample: the smoothed count, the environment baseline and the key
// state. A sample beat lands in an input register; once the output register
// is free or draining, it runs through the combinational update logic and
// the result is written into the output register while the tracker state
// updates. Throughput is one sample per clock while the consumer takes every
// result. The input side keeps taking beats while a finished result waits in
// the output register, so a stalled consumer holds off the producer only
// once both registers are full. Tuning registers are written through the
// plain write port and must only change while no sample is in flight.
`default_nettype none

module touch_key_baseline_detector_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	tkbd_sample_if.sink                      sample_ch,
	tkbd_result_if.source                    result_ch,
	input  logic                             cfg_we,
	input  logic [tkbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tkbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tkbd_pkg::*;

	cfg_t    cfg;
	result_t result;

	logic    valid_s1;
	count_t  raw_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    advance;

	tkbd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// advance the held sample when the output register is free or draining
	assign advance         = valid_s1 && (!out_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;

	// input register: capture a beat, drop the entry once it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready)
			raw_s1 <= sample_ch.raw_count;
	end

	tkbd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.raw_count (raw_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// output register: load on advance, hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result;
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.key_pressed    = out_q.key_pressed;
	assign result_ch.filtered_count = out_q.filtered_count;
	assign result_ch.baseline_level = out_q.baseline_level;

endmodule

`default_nettype wire

>>> design/tkbd_checker.sv
// Port-level checks for the touch key baseline detector.
// Depends on tkbd_pkg; bound to touch_key_baseline_detector_unit below.
`default_nettype none

module tkbd_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_valid,
	input logic                     s_ready,
	input logic                     r_valid,
	input logic                     r_ready,
	input logic                     r_key_pressed,
	input tkbd_pkg::count_t         r_filtered_count,
	input tkbd_pkg::count_t         r_baseline_level
);
	import tkbd_pkg::*;

	// a stalled result beat stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !r_ready) |=> r_valid)
		else $error("result valid dropped while stalled");

	// a stalled result beat keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !r_ready) |=> ($stable(r_key_pressed) &&
			$stable(r_filtered_count) && $stable(r_baseline_level)))
		else $error("result payload changed while stalled");

	// an empty output register never blocks the sample side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid |-> s_ready)
		else $error("sample side stalled with output empty");

	// every accepted sample must be followed by result valid once it has passed the input and output registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> ##1 r_valid)
		else $error("no result after accepted sample");

endmodule

bind touch_key_baseline_detector_unit tkbd_checker u_tkbd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.s_valid          (sample_ch.valid),
	.s_ready          (sample_ch.ready),
	.r_valid          (result_ch.valid),
	.r_ready          (result_ch.ready),
	.r_key_pressed    (result_ch.key_pressed),
	.r_filtered_count (result_ch.filtered_count),
	.r_baseline_level (result_ch.baseline_level)
);

`default_nettype wire
